// File: rtl/imu6_pkg.sv
package imu6_pkg;

   localparam int AXIS_COUNT = 3;
   localparam int LANE_COUNT = 2 * AXIS_COUNT;
   localparam int CUT_W      = 16;
   localparam int STEP_W     = 20;
   localparam int ALPHA_W    = 24;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // 2*pi in Q24 and 1e7 * 2^24 for the alpha denominator
   localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;
   localparam logic [63:0] DEN_BASE   = 64'd167772160000000;

   // alpha unit sequence: product, two partial products, seed, then divide
   localparam logic [4:0] AL_MUL_CT   = 5'd0;
   localparam logic [4:0] AL_MUL_LO   = 5'd1;
   localparam logic [4:0] AL_MUL_HI   = 5'd2;
   localparam logic [4:0] AL_DIV_INIT = 5'd3;
   localparam logic [4:0] AL_LAST     = 5'd27;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_CUT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_CUT  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_STEP  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEP  = 8'd3;

   typedef enum logic [1:0] {
      OC_FILTERED = 2'd0,
      OC_FIRST    = 2'd1,
      OC_RESEED   = 2'd2,
      OC_CLEARED  = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      LOP_HOLD,
      LOP_CLEAR,
      LOP_SEED,
      LOP_MUL,
      LOP_ADD
   } lane_op_type;

   typedef struct packed {
      lane_op_type        op;
      logic [ALPHA_W-1:0] alpha;
   } lane_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALPHA,
      ST_MUL,
      ST_ADD,
      ST_OUT
   } state_type;

endpackage

// File: rtl/imu_six_axis_pt1_lowpass.sv
// six-axis first-order low-pass for IMU samples
// req_ channel: one word holds three accelerations, three angular rates,
// the step since the previous sample and a bad-sample flag; it is taken
// when req_valid is high and req_stall low. req_stall is high while a
// word is being worked on.
// rsp_ channel: one word per request with the six filtered axes and an
// outcome code; rsp_valid holds with the word until rsp_stall is low.
// csr_ channel: register writes, always ready; write only while idle.
// from the accepting edge to rsp_valid, the smoothing factor units form
// a product, two partial products and a seed, then one quotient bit per
// cycle over 24 bits; then come decide, multiply, add and response
// register steps. Both groups run in parallel units. A new request is
// taken while the previous response still waits in the output register.
// six lanes update in parallel, then the merge stage registers the word.
// reset: registers return to their defaults, states clear, filter unprimed.
// a stalled response only delays the return to accepting requests once
// the next word is done.
module imu_six_axis_pt1_lowpass
   import imu6_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 32
)(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_x,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_y,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_z,
   input  logic signed [SAMPLE_WIDTH-1:0] req_rate_x,
   input  logic signed [SAMPLE_WIDTH-1:0] req_rate_y,
   input  logic signed [SAMPLE_WIDTH-1:0] req_rate_z,
   input  logic        [STEP_W-1:0]       req_step_us,
   input  logic                           req_sample_bad,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_smooth_accel_x,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_smooth_accel_y,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_smooth_accel_z,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_smooth_rate_x,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_smooth_rate_y,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_smooth_rate_z,
   output logic        [1:0]              rsp_outcome,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic        [CSR_IDX_W-1:0]    csr_index,
   input  logic        [CSR_DATA_W-1:0]   csr_data
);

   state_type state_ff, state_in;

   logic [CUT_W-1:0]  accel_cut_ff;
   logic [CUT_W-1:0]  gyro_cut_ff;
   logic [STEP_W-1:0] min_step_ff;
   logic [STEP_W-1:0] max_step_ff;

   logic signed [SAMPLE_WIDTH-1:0] x_ff [LANE_COUNT];
   logic signed [SAMPLE_WIDTH-1:0] y    [LANE_COUNT];
   logic [STEP_W-1:0]              step_ff;
   logic                           bad_ff;
   logic                           primed_ff, primed_in;
   outcome_type                    outcome_ff, outcome_in;

   logic               accept;
   logic               accel_done, gyro_done;
   logic [ALPHA_W-1:0] accel_factor, gyro_factor;
   lane_op_type        lane_op;
   lane_ctl_type       accel_ctl, gyro_ctl;

   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_y_ff [LANE_COUNT];
   outcome_type                    rsp_outcome_ff;
   logic                           out_load;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_cut_ff <= 16'd100;
         gyro_cut_ff  <= 16'd300;
         min_step_ff  <= 20'd100;
         max_step_ff  <= 20'd100000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ACCEL_CUT: accel_cut_ff <= csr_data[CUT_W-1:0];
            CSR_GYRO_CUT:  gyro_cut_ff  <= csr_data[CUT_W-1:0];
            CSR_MIN_STEP:  min_step_ff  <= csr_data[STEP_W-1:0];
            CSR_MAX_STEP:  max_step_ff  <= csr_data[STEP_W-1:0];
            default:       ;
         endcase
      end
   end

   // smoothing factor units, one per group
   imu6_alpha u_accel_factor (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .cutoff (accel_cut_ff),
      .step   (req_step_us),
      .done   (accel_done),
      .alpha  (accel_factor)
   );

   imu6_alpha u_gyro_factor (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .cutoff (gyro_cut_ff),
      .step   (req_step_us),
      .done   (gyro_done),
      .alpha  (gyro_factor)
   );

   // capture the request word
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff[0] <= req_accel_x;
         x_ff[1] <= req_accel_y;
         x_ff[2] <= req_accel_z;
         x_ff[3] <= req_rate_x;
         x_ff[4] <= req_rate_y;
         x_ff[5] <= req_rate_z;
         step_ff <= req_step_us;
         bad_ff  <= req_sample_bad;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_ALPHA;
         ST_ALPHA: if (accel_done) state_in = ST_MUL;
         ST_MUL:   state_in = ST_ADD;
         ST_ADD:   state_in = ST_OUT;
         ST_OUT:   if (out_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outcome decision and lane commands
   always_comb begin
      outcome_in = outcome_ff;
      primed_in  = primed_ff;
      lane_op    = LOP_HOLD;
      unique case (state_ff)
         ST_ALPHA: begin
            if (accel_done) begin
               if (bad_ff) begin
                  outcome_in = OC_CLEARED;
               end else if (!primed_ff) begin
                  outcome_in = OC_FIRST;
               end else if (step_ff < min_step_ff || step_ff > max_step_ff ||
                            accel_factor == '0 || gyro_factor == '0) begin
                  outcome_in = OC_RESEED;
               end else begin
                  outcome_in = OC_FILTERED;
               end
            end
         end
         ST_MUL: lane_op = LOP_MUL;
         ST_ADD: begin
            unique case (outcome_ff)
               OC_FILTERED: lane_op = LOP_ADD;
               OC_CLEARED:  lane_op = LOP_CLEAR;
               default:     lane_op = LOP_SEED;
            endcase
            primed_in = (outcome_ff != OC_CLEARED);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         primed_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         primed_ff <= primed_in;
      end
      outcome_ff <= outcome_in;
   end

   assign accel_ctl = '{op: lane_op, alpha: accel_factor};
   assign gyro_ctl  = '{op: lane_op, alpha: gyro_factor};

   // six filter lanes
   for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
      imu6_lane #(
         .WIDTH (SAMPLE_WIDTH)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   ((i < AXIS_COUNT) ? accel_ctl : gyro_ctl),
         .x     (x_ff[i]),
         .y     (y[i])
      );
   end

   // merge stage: response word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         for (int i = 0; i < LANE_COUNT; i++) begin
            rsp_y_ff[i] <= y[i];
         end
         rsp_outcome_ff <= outcome_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_smooth_accel_x = rsp_y_ff[0];
   assign rsp_smooth_accel_y = rsp_y_ff[1];
   assign rsp_smooth_accel_z = rsp_y_ff[2];
   assign rsp_smooth_rate_x  = rsp_y_ff[3];
   assign rsp_smooth_rate_y  = rsp_y_ff[4];
   assign rsp_smooth_rate_z  = rsp_y_ff[5];
   assign rsp_outcome        = rsp_outcome_ff;

`ifndef NO_ASSERTIONS
   a_alpha_lockstep: assert property (@(posedge clock) disable iff (reset)
      accel_done |-> gyro_done)
      else $error("alpha units out of step");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_ALPHA)
      else $error("accepted word did not start alpha");

   a_cleared_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_outcome_ff == OC_CLEARED |->
      rsp_y_ff[0] == '0 && rsp_y_ff[5] == '0)
      else $error("cleared response carries nonzero data");

   a_unprimed_after_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD && outcome_ff == OC_CLEARED |=> !primed_ff)
      else $error("primed after bad sample");
`endif

endmodule

// File: rtl/imu6_alpha.sv
module imu6_alpha
   import imu6_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [CUT_W-1:0]   cutoff,
   input  logic [STEP_W-1:0]  step,
   output logic               done,
   output logic [ALPHA_W-1:0] alpha
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic [CUT_W+STEP_W-1:0] ct_ff, ct_in;
   logic [63:0]             num_ff, num_in;
   logic [63:0]             den_ff, den_in;
   logic [63:0]             rem_ff, rem_in;
   logic [ALPHA_W-1:0]      q_ff, q_in;
   logic [63:0]             rem_sh;
   logic                    ge;

   // operands held for the product cycle
   logic [CUT_W-1:0]  cutoff_q;
   logic [STEP_W-1:0] step_q;

   // one quotient bit per cycle, restoring
   assign rem_sh = {rem_ff[62:0], 1'b0};
   assign ge     = (rem_sh >= den_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ct_in   = ct_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = AL_MUL_CT;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 5'd1;
         case (cnt_ff)
            AL_MUL_CT: ct_in = {{STEP_W{1'b0}}, cutoff_q} * {{CUT_W{1'b0}}, step_q};
            AL_MUL_LO: num_in = 64'(ct_ff[17:0]) * 64'(TWO_PI_Q24);
            AL_MUL_HI: num_in = num_ff +
                                {1'b0, 45'(ct_ff[35:18]) * 45'(TWO_PI_Q24), 18'd0};
            AL_DIV_INIT: begin
               den_in = DEN_BASE + num_ff;
               rem_in = num_ff;
               q_in   = '0;
            end
            default: begin
               rem_in = ge ? (rem_sh - den_ff) : rem_sh;
               q_in   = {q_ff[ALPHA_W-2:0], ge};
               if (cnt_ff == AL_LAST) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cutoff_q <= cutoff;
         step_q   <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ct_ff  <= ct_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done  = done_ff;
   assign alpha = q_ff;

endmodule

// File: rtl/imu6_lane.sv
module imu6_lane
   import imu6_pkg::*;
#(
   parameter int WIDTH = 32
)(
   input  logic                    clock,
   input  logic                    reset,
   input  lane_ctl_type            ctl,
   input  logic signed [WIDTH-1:0] x,
   output logic signed [WIDTH-1:0] y
);

   localparam int PW = WIDTH + 1 + ALPHA_W + 1;

   logic signed [WIDTH-1:0] y_ff, y_in;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [WIDTH:0]   diff;

   // exact difference, one bit wider than a sample
   assign diff    = {x[WIDTH-1], x} - {y_ff[WIDTH-1], y_ff};
   assign prod_in = PW'(diff) * PW'($signed({1'b0, ctl.alpha}));

   // track update: clear, seed from the sample, or floor of product over 2^24 added to the state
   always_comb begin
      y_in = y_ff;
      case (ctl.op)
         LOP_CLEAR: y_in = '0;
         LOP_SEED:  y_in = x;
         LOP_ADD:   y_in = y_ff + prod_ff[WIDTH+ALPHA_W-1:ALPHA_W];
         default:   y_in = y_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_ff <= '0;
      end else begin
         y_ff <= y_in;
      end
      if (ctl.op == LOP_MUL) begin
         prod_ff <= prod_in;
      end
   end

   assign y = y_ff;

endmodule
